// File: src/iol_pkg.sv
// shared types and codes for the indexed ordered list
package iol_pkg;

  localparam int WORD_W = 32;
  localparam int OPCODE_W = 3;
  localparam int POS_W = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 5;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PREPEND = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SET     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_GET     = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // per-cell actions
  localparam logic [1:0] ACT_HOLD   = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]        act;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

// File: src/indexed_ordered_list_top.sv
// indexed ordered list: top level with control, cell chain and result register

// An ordered list of up to DEPTH signed 32-bit words held in a row of DEPTH
// cells. Each input word carries opcode, position and data_in; each one gives
// exactly one result word with data_out, status and count_out. On the edge
// that accepts an item every cell shifts, loads or holds in parallel, and the
// result lands in the output register on that same edge, so the result
// appears in the cycle after acceptance and a new item can be accepted every
// cycle while the output side keeps taking results (the single output
// register sets that rate). Get and remove read the word at the position
// through the OR of the cells' gated outputs. Stored words have no reset and
// no clearing pass; only the length is cleared, and words beyond the length
// are never returned. count_out carries the low five bits of the length.
module indexed_ordered_list_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // opcode[2:0], position[7:3], data_in[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // data_out[31:0], status[33:32], count_out[38:34], zero
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  // common compare width for position and length
  localparam int CW   = (CNTW > iol_pkg::POS_W) ? CNTW : iol_pkg::POS_W;
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  // input fields
  logic [iol_pkg::OPCODE_W-1:0] opcode;
  logic [iol_pkg::POS_W-1:0]    position;
  logic [iol_pkg::WORD_W-1:0]   data_in;

  assign opcode   = s_tdata[2:0];
  assign position = s_tdata[7:3];
  assign data_in  = s_tdata[39:8];

  // control state
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;
  logic            out_valid;

  // result register
  logic [iol_pkg::WORD_W-1:0]      data_out;
  logic [iol_pkg::STATUS_W-1:0]    status;
  logic [iol_pkg::COUNT_OUT_W-1:0] count_out;

  logic s_fire;
  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  // compare position against length at a common width
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] cnt_next_ext;
  logic          full;
  logic          pos_le_cnt;
  logic          pos_lt_cnt;

  assign pos_ext    = CW'(position);
  assign cnt_ext    = CW'(count);
  assign full       = (cnt_ext == DEPTH_CW);
  assign pos_le_cnt = (pos_ext <= cnt_ext);
  assign pos_lt_cnt = (pos_ext < cnt_ext);

  // per-item decode
  iol_pkg::cell_cmd_t          cmd;
  logic [IW-1:0]               cell_pos;
  logic [iol_pkg::STATUS_W-1:0] st;
  logic                        take_read;

  always_comb begin
    cmd.act    = iol_pkg::ACT_HOLD;
    cmd.word   = data_in;
    cell_pos   = IW'(position);
    st         = iol_pkg::ST_OK;
    count_next = count;
    take_read  = 1'b0;
    case (opcode)
      iol_pkg::OP_APPEND: begin
        if (full) begin
          st = iol_pkg::ST_FULL;
        end else begin
          cmd.act    = iol_pkg::ACT_INSERT;
          cell_pos   = IW'(count);
          count_next = count + 1'b1;
        end
      end
      iol_pkg::OP_PREPEND: begin
        if (full) begin
          st = iol_pkg::ST_FULL;
        end else begin
          cmd.act    = iol_pkg::ACT_INSERT;
          cell_pos   = '0;
          count_next = count + 1'b1;
        end
      end
      iol_pkg::OP_INSERT: begin
        // range is checked before full
        if (!pos_le_cnt) begin
          st = iol_pkg::ST_RANGE;
        end else if (full) begin
          st = iol_pkg::ST_FULL;
        end else begin
          cmd.act    = iol_pkg::ACT_INSERT;
          count_next = count + 1'b1;
        end
      end
      iol_pkg::OP_SET: begin
        if (!pos_lt_cnt) st = iol_pkg::ST_RANGE;
        else cmd.act = iol_pkg::ACT_SET;
      end
      iol_pkg::OP_REMOVE: begin
        if (!pos_lt_cnt) begin
          st = iol_pkg::ST_RANGE;
        end else begin
          cmd.act    = iol_pkg::ACT_REMOVE;
          take_read  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      iol_pkg::OP_GET: begin
        if (!pos_lt_cnt) st = iol_pkg::ST_RANGE;
        else take_read = 1'b1;
      end
      iol_pkg::OP_CLEAR: count_next = '0;
      default: st = iol_pkg::ST_OK;
    endcase
    // cells only move on an accepted item
    if (!s_fire) cmd.act = iol_pkg::ACT_HOLD;
  end

  // cell chain
  logic [iol_pkg::WORD_W-1:0] cell_word [DEPTH];
  logic [iol_pkg::WORD_W-1:0] hit_word  [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [iol_pkg::WORD_W-1:0] left_word;
      logic [iol_pkg::WORD_W-1:0] right_word;
      if (gi == 0) begin : g_first
        assign left_word = '0;
      end else begin : g_mid_l
        assign left_word = cell_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_word = '0;
      end else begin : g_mid_r
        assign right_word = cell_word[gi+1];
      end
      iol_cell #(
        .IW    (IW),
        .INDEX (gi)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .pos        (cell_pos),
        .left_word  (left_word),
        .right_word (right_word),
        .word       (cell_word[gi]),
        .hit_word   (hit_word[gi])
      );
    end
  endgenerate

  // read word: only the addressed cell drives a nonzero value
  logic [iol_pkg::WORD_W-1:0] read_word;
  always_comb begin
    read_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_word = read_word | hit_word[i];
    end
  end

  assign cnt_next_ext = CW'(count_next);

  // length and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_fire) count <= count_next;
      if (s_fire) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      data_out  <= take_read ? read_word : '0;
      status    <= st;
      count_out <= cnt_next_ext[iol_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, count_out, status, data_out};

  // checks
  assert property (@(posedge clk) disable iff (rst) CW'(count) <= DEPTH_CW)
    else $error("length exceeds depth");

  assert property (@(posedge clk) disable iff (rst)
    s_fire && (st != iol_pkg::ST_OK) |=> count == $past(count))
    else $error("failed operation changed the length");

  assert property (@(posedge clk) disable iff (rst)
    s_fire && (opcode == iol_pkg::OP_GET || opcode == iol_pkg::OP_SET)
    |=> count == $past(count))
    else $error("get or set changed the length");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status != 2'd3)
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    s_fire && (st == iol_pkg::ST_FULL) |-> full)
    else $error("full reported below depth");

endmodule

// File: src/iol_cell.sv
// one storage cell of the list chain
module iol_cell #(
  parameter int IW = 4,
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  iol_pkg::cell_cmd_t         cmd,
  input  logic [IW-1:0]              pos,
  input  logic [iol_pkg::WORD_W-1:0] left_word,
  input  logic [iol_pkg::WORD_W-1:0] right_word,
  output logic [iol_pkg::WORD_W-1:0] word,
  output logic [iol_pkg::WORD_W-1:0] hit_word
);

  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

  logic                       at_pos;
  logic                       above_pos;
  logic [iol_pkg::WORD_W-1:0] word_next;

  assign at_pos    = (pos == MY_INDEX);
  assign above_pos = (MY_INDEX > pos);
  assign hit_word  = at_pos ? word : '0;

  always_comb begin
    word_next = word;
    case (cmd.act)
      iol_pkg::ACT_HOLD: word_next = word;
      iol_pkg::ACT_SET: begin
        if (at_pos) word_next = cmd.word;
      end
      iol_pkg::ACT_INSERT: begin
        if (at_pos) word_next = cmd.word;
        else if (above_pos) word_next = left_word;
      end
      iol_pkg::ACT_REMOVE: begin
        if (at_pos || above_pos) word_next = right_word;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// File: bench/tb.sv
// self-checking stream testbench for the indexed ordered list
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;
  // generous cycle budget, many times the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT = 10;
  // the block treats the one spare opcode as a no-op
  localparam logic [iol_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;

  // one expected result word
  typedef struct {
    logic [iol_pkg::WORD_W-1:0]      rd_word;
    logic [iol_pkg::STATUS_W-1:0]    status;
    logic [iol_pkg::COUNT_OUT_W-1:0] length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // opcode[2:0], position[7:3], data_in[39:8]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // data_out[31:0], status[33:32], count_out[38:34], zero

  // shadow copy of the list, updated when a word is accepted
  logic [iol_pkg::WORD_W-1:0] list_words [LIST_DEPTH];
  int                         list_len = 0;
  list_result_t               expected_results [$];

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off, requested by a test and counted by the receiver
  int hold_req = 0;
  int hold_left = 0;

  int err_count = 0;
  int shown_count = 0;
  int cycle_count = 0;

  indexed_ordered_list_top #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // make room at pos by moving later entries up one place
  function automatic void open_slot(input int pos);
    int i;
    for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
  endfunction

  // compute the result of one accepted word and advance the shadow list
  function automatic void predict_list_op(input logic [iol_pkg::OPCODE_W-1:0] op,
                                          input logic [iol_pkg::POS_W-1:0] pos,
                                          input logic [iol_pkg::WORD_W-1:0] word);
    list_result_t res;
    int           idx;
    int           i;
    idx = int'(pos);
    res.rd_word = '0;
    res.status = iol_pkg::ST_OK;
    case (op)
      iol_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH) res.status = iol_pkg::ST_FULL;
        else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      iol_pkg::OP_PREPEND: begin
        if (list_len >= LIST_DEPTH) res.status = iol_pkg::ST_FULL;
        else begin
          open_slot(0);
          list_words[0] = word;
          list_len++;
        end
      end
      iol_pkg::OP_INSERT: begin
        // a bad position wins over a full list
        if (idx > list_len) res.status = iol_pkg::ST_RANGE;
        else if (list_len >= LIST_DEPTH) res.status = iol_pkg::ST_FULL;
        else begin
          open_slot(idx);
          list_words[idx] = word;
          list_len++;
        end
      end
      iol_pkg::OP_SET: begin
        if (idx >= list_len) res.status = iol_pkg::ST_RANGE;
        else list_words[idx] = word;
      end
      iol_pkg::OP_REMOVE: begin
        if (idx >= list_len) res.status = iol_pkg::ST_RANGE;
        else begin
          res.rd_word = list_words[idx];
          for (i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      iol_pkg::OP_GET: begin
        if (idx >= list_len) res.status = iol_pkg::ST_RANGE;
        else res.rd_word = list_words[idx];
      end
      iol_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.length = iol_pkg::COUNT_OUT_W'(list_len);
    expected_results.push_back(res);
  endfunction

  // data with a good share of the extremes
  function automatic logic [iol_pkg::WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h8000_0000;
    else if (r < 16) return 32'h7fff_ffff;
    else if (r < 20) return 32'h0000_0000;
    else if (r < 24) return 32'hffff_ffff;
    else return $urandom;
  endfunction

  // offer one word, keep tvalid high afterwards unless the next call idles
  task automatic send_word(input logic [iol_pkg::OPCODE_W-1:0] op,
                           input logic [iol_pkg::POS_W-1:0] pos,
                           input logic [iol_pkg::WORD_W-1:0] word);
    // each idle cycle is drawn on its own, so the idle share matches the knob
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {word, pos, op};
    do @(posedge clk); while (!s_tready);
    predict_list_op(op, pos, word);
  endtask

  // stop sending until every expected result has come back
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver: long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        err_count++;
        if (shown_count < SHOW_LIMIT) begin
          shown_count++;
          $display("unexpected result word %h", m_tdata);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (m_tdata[31:0] !== exp_res.rd_word || m_tdata[33:32] !== exp_res.status ||
            m_tdata[38:34] !== exp_res.length) begin
          err_count++;
          if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display(
              "mismatch: data_out exp %h got %h, status exp %0d got %0d, count exp %0d got %0d",
              exp_res.rd_word, m_tdata[31:0], exp_res.status, m_tdata[33:32],
              exp_res.length, m_tdata[38:34]);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // on an empty list, get, remove, set and an insert past the end are out of range; the spare opcode is a no-op
  task automatic test_empty_list();
    send_word(iol_pkg::OP_GET, 5'd0, 32'h0);
    send_word(iol_pkg::OP_REMOVE, 5'd0, 32'h0);
    send_word(iol_pkg::OP_INSERT, 5'd1, 32'h1234_5678);
    send_word(iol_pkg::OP_SET, 5'd0, 32'hffff_ffff);
    send_word(OP_UNUSED, 5'd31, 32'hffff_ffff);
  endtask

  // fill through all three growing operations, hit full and range edges, then get, remove and clear
  task automatic test_fill_and_full();
    int i;
    send_word(iol_pkg::OP_INSERT, 5'd0, 32'h0000_0000);
    send_word(iol_pkg::OP_APPEND, 5'd0, 32'h7fff_ffff);
    send_word(iol_pkg::OP_PREPEND, 5'd0, 32'h8000_0000);
    send_word(iol_pkg::OP_INSERT, 5'd1, 32'hffff_ffff);
    send_word(iol_pkg::OP_APPEND, 5'd0, 32'h0000_0001);
    // insert at the end position alternates with append
    for (i = 0; i < 11; i++) begin
      if (i % 2 == 0) send_word(iol_pkg::OP_INSERT, iol_pkg::POS_W'(list_len), pick_word());
      else send_word(iol_pkg::OP_APPEND, iol_pkg::POS_W'(i), pick_word());
    end
    send_word(iol_pkg::OP_APPEND, 5'd0, 32'h5555_5555);
    send_word(iol_pkg::OP_INSERT, 5'd16, 32'haaaa_aaaa);
    // bad position reported even though the list is full
    send_word(iol_pkg::OP_INSERT, 5'd17, 32'haaaa_aaaa);
    send_word(iol_pkg::OP_GET, 5'd15, 32'h0);
    send_word(iol_pkg::OP_GET, 5'd31, 32'h0);
    send_word(iol_pkg::OP_REMOVE, 5'd0, 32'h0);
    send_word(iol_pkg::OP_CLEAR, 5'd0, 32'h0);
  endtask

  // random traffic, mostly legal positions, bias swings between growth and shrink
  task automatic random_burst(input int n_words);
    int                             k;
    int                             r;
    int                             grow_pct;
    logic [iol_pkg::OPCODE_W-1:0]   op;
    logic [iol_pkg::POS_W-1:0]      pos;
    grow_pct = 70;
    for (k = 0; k < n_words; k++) begin
      if (k % 40 == 0) grow_pct = (grow_pct == 70) ? 30 : 70;
      r = $urandom_range(0, 99);
      if (r < 2) op = iol_pkg::OP_CLEAR;
      else if (r < 4) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < grow_pct)
        op = iol_pkg::OPCODE_W'($urandom_range(iol_pkg::OP_APPEND, iol_pkg::OP_INSERT));
      else op = iol_pkg::OPCODE_W'($urandom_range(iol_pkg::OP_SET, iol_pkg::OP_GET));
      if ($urandom_range(0, 99) < 85) pos = iol_pkg::POS_W'($urandom_range(0, list_len));
      else pos = iol_pkg::POS_W'($urandom_range(0, 31));
      send_word(op, pos, pick_word());
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_burst(265);
    send_idle_pct = 48;
    recv_stall_pct = 0;
    random_burst(265);
    send_idle_pct = 0;
    recv_stall_pct = 48;
    random_burst(265);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_burst(265);
  endtask

  // receiver holds off for a long time while the sender keeps offering
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 300;
    random_burst(40);
    wait_results_done();
  endtask

  // sender pauses until all results are in, then resumes
  task automatic test_sender_pause();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_burst(25);
    wait_results_done();
    repeat ($urandom_range(1, 6)) @(posedge clk);
    random_burst(25);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_fill_and_full();
    test_random_traffic();
    test_back_pressure();
    test_sender_pause();
    // drain, then give the output register time to settle
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_results_done();
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
